### sv/a2k_pkg.sv
`default_nettype none

package a2k_pkg;

    localparam logic       CMD_TYPE = 1'b0;
    localparam logic       CMD_LOAD = 1'b1;

    localparam logic [1:0] ST_KEY    = 2'd0;
    localparam logic [1:0] ST_MISS   = 2'd1;
    localparam logic [1:0] ST_STORED = 2'd2;
    localparam logic [1:0] ST_FULL   = 2'd3;

    localparam logic [7:0] SHIFT_KEY = 8'd16;
    localparam logic [7:0] CODE_SPACE = 8'd32;
    localparam logic [7:0] CODE_TAB   = 8'd9;
    localparam logic [7:0] CODE_ENTER = 8'd13;
    localparam logic [7:0] CASE_OFFSET = 8'd32;

    localparam logic [7:0] CHR_SPACE = 8'h20;
    localparam logic [7:0] CHR_TAB   = 8'h09;
    localparam logic [7:0] CHR_LF    = 8'h0A;
    localparam logic [7:0] CHR_ZERO  = 8'h30;
    localparam logic [7:0] CHR_NINE  = 8'h39;
    localparam logic [7:0] CHR_UP_A  = 8'h41;
    localparam logic [7:0] CHR_UP_Z  = 8'h5A;
    localparam logic [7:0] CHR_LO_A  = 8'h61;
    localparam logic [7:0] CHR_LO_Z  = 8'h7A;

    // event sequence shapes
    typedef enum logic [1:0] {
        SEQ_STATUS,   // one status word
        SEQ_PAIR,     // press, release
        SEQ_LOWER,    // press, release, shift release
        SEQ_WRAP      // shift press, press, release, shift release
    } t_seq;

    typedef struct packed {
        t_seq       seq;
        logic [7:0] code;
    } t_plan;

    typedef struct packed {
        logic signed [8:0] code;
        logic [7:0]        match;
    } t_entry;

    typedef struct packed {
        logic accept;
        logic search;
        logic load_hit;
        logic load_miss;
        logic emit;
    } t_dp_cmd;

    typedef struct packed {
        logic is_load;
        logic fixed;
        logic hit;
        logic miss;
        logic out_free;
        logic emit_last;
    } t_dp_stat;

    function automatic logic is_fixed(input logic [7:0] ch);
        return (ch >= CHR_ZERO && ch <= CHR_NINE) || (ch >= CHR_UP_A && ch <= CHR_UP_Z) ||
               (ch >= CHR_LO_A && ch <= CHR_LO_Z) || ch == CHR_SPACE || ch == CHR_TAB ||
               ch == CHR_LF;
    endfunction

    function automatic t_plan fixed_plan(input logic [7:0] ch);
        t_plan p;
        p.seq  = SEQ_PAIR;
        p.code = ch;
        if (ch >= CHR_UP_A && ch <= CHR_UP_Z) begin
            p.seq = SEQ_WRAP;
        end else if (ch >= CHR_LO_A && ch <= CHR_LO_Z) begin
            p.seq  = SEQ_LOWER;
            p.code = ch - CASE_OFFSET;
        end else if (ch == CHR_SPACE) begin
            p.code = CODE_SPACE;
        end else if (ch == CHR_TAB) begin
            p.code = CODE_TAB;
        end else if (ch == CHR_LF) begin
            p.code = CODE_ENTER;
        end
        return p;
    endfunction

    function automatic t_plan table_plan(input logic signed [8:0] v);
        t_plan      p;
        logic [9:0] neg;
        neg = 10'd0 - {v[8], v};
        if (v[8]) begin
            p.seq  = SEQ_WRAP;
            // magnitude 256 saturates
            p.code = neg[8] ? 8'hFF : neg[7:0];
        end else begin
            p.seq  = SEQ_PAIR;
            p.code = v[7:0];
        end
        return p;
    endfunction

endpackage

`default_nettype wire

### sv/a2k_ctrl.sv
`default_nettype none

module a2k_ctrl (
    input  wire                i_clk,
    input  wire                i_rst_n,
    input  wire                i_in_valid,
    output logic               o_in_ready,
    input  a2k_pkg::t_dp_stat  i_stat,
    output a2k_pkg::t_dp_cmd   o_cmd
);
    import a2k_pkg::*;

    localparam logic [1:0] S_IDLE   = 2'd0;
    localparam logic [1:0] S_SEARCH = 2'd1;
    localparam logic [1:0] S_EMIT   = 2'd2;

    logic [1:0] r_state;
    logic [1:0] n_state;
    logic       w_accept;

    assign o_in_ready = (r_state == S_IDLE);
    assign w_accept   = i_in_valid && o_in_ready;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    o_cmd.accept = 1'b1;
                    n_state = (i_stat.is_load || i_stat.fixed) ? S_EMIT : S_SEARCH;
                end
            end
            S_SEARCH: begin
                o_cmd.search = 1'b1;
                if (i_stat.hit) begin
                    o_cmd.load_hit = 1'b1;
                    n_state = S_EMIT;
                end else if (i_stat.miss) begin
                    o_cmd.load_miss = 1'b1;
                    n_state = S_EMIT;
                end
            end
            S_EMIT: begin
                if (i_stat.out_free) begin
                    o_cmd.emit = 1'b1;
                    if (i_stat.emit_last) begin
                        n_state = S_IDLE;
                    end
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    a_last_to_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.emit && i_stat.emit_last |=> r_state == S_IDLE)
        else $error("controller did not return to idle after last word");

    a_load_skips_search: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept && i_stat.is_load |=> r_state == S_EMIT)
        else $error("table load entered search");

endmodule

`default_nettype wire

### sv/a2k_datapath.sv
`default_nettype none

module a2k_datapath #(
    parameter int TABLE_DEPTH = 64
) (
    input  wire                i_clk,
    input  wire                i_rst_n,
    input  a2k_pkg::t_dp_cmd   i_cmd,
    output a2k_pkg::t_dp_stat  o_stat,
    input  wire                i_in_load,
    input  wire [7:0]          i_in_char,
    input  wire [7:0]          i_entry_char,
    input  wire signed [8:0]   i_entry_code,
    output logic               o_out_valid,
    input  wire                i_out_ready,
    output logic [7:0]         o_key_code,
    output logic               o_key_release,
    output logic [1:0]         o_status,
    output logic               o_last
);
    import a2k_pkg::*;

    localparam int CNT_W = $clog2(TABLE_DEPTH + 1);
    localparam int AW    = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam logic [CNT_W-1:0] DEPTH_C = CNT_W'(TABLE_DEPTH);

    t_entry           r_mem [TABLE_DEPTH];
    t_entry           r_rd_word;
    logic             r_rd_valid;
    logic [CNT_W-1:0] r_count;
    logic [CNT_W-1:0] r_ptr;
    logic [7:0]       r_char;
    t_seq             r_seq;
    logic [7:0]       r_code;
    logic [1:0]       r_stat_code;
    logic [1:0]       r_step;

    logic             w_full;
    logic             w_issue;
    t_plan            w_fixed;
    t_plan            w_tab;
    logic [7:0]       w_code;
    logic             w_rel;
    logic [1:0]       w_status;
    logic             w_last;

    assign w_full  = (r_count == DEPTH_C);
    assign w_issue = i_cmd.search && (r_ptr < r_count);
    assign w_fixed = fixed_plan(i_in_char);
    assign w_tab   = table_plan(r_rd_word.code);

    assign o_stat.is_load   = (i_in_load == CMD_LOAD);
    assign o_stat.fixed     = is_fixed(i_in_char);
    assign o_stat.hit       = r_rd_valid && (r_rd_word.match == r_char);
    assign o_stat.miss      = !r_rd_valid && (r_ptr >= r_count);
    assign o_stat.out_free  = !o_out_valid || i_out_ready;
    assign o_stat.emit_last = w_last;

    // current word of the event sequence
    always_comb begin
        w_code   = r_code;
        w_rel    = 1'b0;
        w_status = ST_KEY;
        w_last   = 1'b0;
        case (r_seq)
            SEQ_STATUS: begin
                w_code   = 8'd0;
                w_status = r_stat_code;
                w_last   = 1'b1;
            end
            SEQ_PAIR: begin
                w_rel  = r_step[0];
                w_last = (r_step == 2'd1);
            end
            SEQ_LOWER: begin
                w_rel  = (r_step != 2'd0);
                w_last = (r_step == 2'd2);
                if (r_step == 2'd2) begin
                    w_code = SHIFT_KEY;
                end
            end
            SEQ_WRAP: begin
                w_rel  = r_step[1];
                w_last = (r_step == 2'd3);
                if (r_step == 2'd0 || r_step == 2'd3) begin
                    w_code = SHIFT_KEY;
                end
            end
            default: begin
                w_last = 1'b1;
            end
        endcase
    end

    // table memory
    always_ff @(posedge i_clk) begin
        if (i_cmd.accept && o_stat.is_load && !w_full) begin
            r_mem[r_count[AW-1:0]] <= '{code: i_entry_code, match: i_entry_char};
        end
        if (w_issue) begin
            r_rd_word <= r_mem[r_ptr[AW-1:0]];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count    <= '0;
            r_rd_valid <= 1'b0;
            r_step     <= 2'd0;
        end else begin
            r_rd_valid <= w_issue;
            if (i_cmd.accept && o_stat.is_load && !w_full) begin
                r_count <= r_count + 1'b1;
            end
            if (i_cmd.accept || i_cmd.load_hit || i_cmd.load_miss) begin
                r_step <= 2'd0;
            end else if (i_cmd.emit) begin
                r_step <= r_step + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_char <= i_in_char;
            r_ptr  <= '0;
            if (o_stat.is_load) begin
                r_seq       <= SEQ_STATUS;
                r_stat_code <= w_full ? ST_FULL : ST_STORED;
            end else begin
                r_seq  <= w_fixed.seq;
                r_code <= w_fixed.code;
            end
        end else if (w_issue) begin
            r_ptr <= r_ptr + 1'b1;
        end
        if (i_cmd.load_hit) begin
            r_seq  <= w_tab.seq;
            r_code <= w_tab.code;
        end else if (i_cmd.load_miss) begin
            r_seq       <= SEQ_STATUS;
            r_stat_code <= ST_MISS;
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_out_valid <= 1'b0;
        end else if (i_cmd.emit) begin
            o_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            o_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit) begin
            o_key_code    <= w_code;
            o_key_release <= w_rel;
            o_status      <= w_status;
            o_last        <= w_last;
        end
    end

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= DEPTH_C)
        else $error("entry count beyond table depth");

    a_full_keeps_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.accept && o_stat.is_load && w_full |=> $stable(r_count))
        else $error("load into full table changed count");

    a_store_bumps_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.accept && o_stat.is_load && !w_full |=> r_count == $past(r_count) + 1'b1)
        else $error("stored entry did not advance count");

endmodule

`default_nettype wire

### sv/ascii_to_keystroke_encoder_top.sv
// text byte to key event encoder
//
// input stream: one word per command. tuser[0] selects typing a character (0) or
// appending a lookup table entry (1). output stream: one word per key event or
// status, tlast on the final word of each input word.
//
// a load gives one status word: entry stored, or table full (entry dropped).
// digits, letters, space, tab and newline use fixed sequences of two to four
// events. other bytes are searched in the table, first match first, one entry
// per cycle through the table memory's single read port; a miss gives one status.
//
// for fixed and load words the controller moves from accept straight to emit, where
// the output register takes the first word; a table byte passes through search first,
// which ends at the first hit or after every stored entry is read (no read if empty).
// a new input word is taken only once the last result word of the previous one is
// emitted; the event emitter moves one word per cycle while the output register is free.
//
// reset empties the table; no clearing pass is needed. when the receiver stalls,
// the output register holds its word and the emitter waits; the next input word is
// accepted while the final result of the previous one is still held.
`default_nettype none

module ascii_to_keystroke_encoder_top #(
    parameter int TABLE_DEPTH = 64
) (
    input  wire         i_clk,
    input  wire         i_rst_n,
    input  wire         i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  wire [31:0]  i_s_axis_tdata,   // character, entry_char, entry_code, zero pad
    input  wire [0:0]   i_s_axis_tuser,   // cmd
    output logic        o_m_axis_tvalid,
    input  wire         i_m_axis_tready,
    output logic [15:0] o_m_axis_tdata,   // key_code, key_release, zero pad
    output logic [1:0]  o_m_axis_tuser,   // status
    output logic        o_m_axis_tlast
);
    import a2k_pkg::*;

    t_dp_cmd    w_cmd;
    t_dp_stat   w_stat;
    logic [7:0] w_key_code;
    logic       w_key_release;

    a2k_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_s_axis_tvalid),
        .o_in_ready (o_s_axis_tready),
        .i_stat     (w_stat),
        .o_cmd      (w_cmd)
    );

    a2k_datapath #(
        .TABLE_DEPTH (TABLE_DEPTH)
    ) u_datapath (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (w_cmd),
        .o_stat        (w_stat),
        .i_in_load     (i_s_axis_tuser[0]),
        .i_in_char     (i_s_axis_tdata[7:0]),
        .i_entry_char  (i_s_axis_tdata[15:8]),
        .i_entry_code  (i_s_axis_tdata[24:16]),
        .o_out_valid   (o_m_axis_tvalid),
        .i_out_ready   (i_m_axis_tready),
        .o_key_code    (w_key_code),
        .o_key_release (w_key_release),
        .o_status      (o_m_axis_tuser),
        .o_last        (o_m_axis_tlast)
    );

    assign o_m_axis_tdata = {7'd0, w_key_release, w_key_code};

endmodule

`default_nettype wire

### tb/ascii_to_keystroke_encoder_top_test.sv
`timescale 1ns / 100ps

module ascii_to_keystroke_encoder_top_test;
    import a2k_pkg::*;

    localparam int TABLE_DEPTH = 64;
    localparam int RANDOM_WORDS = 500;
    localparam int DRAIN_CYCLES = 20;
    localparam int CYCLE_LIMIT = 500000;

    typedef struct packed {
        logic              cmd;
        logic [7:0]        ch;
        logic [7:0]        entry_char;
        logic signed [8:0] entry_code;
    } t_text_word;

    typedef struct packed {
        logic [7:0] code;
        logic       release_flag;
        logic [1:0] status;
        logic       last;
    } t_keystroke;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        s_valid = 1'b0;
    logic [31:0] s_data = '0;
    logic [0:0]  s_user = '0;
    logic        m_ready = 1'b0;

    wire        s_ready;
    wire        m_valid;
    wire [15:0] m_data;
    wire [1:0]  m_user;
    wire        m_last;

    ascii_to_keystroke_encoder_top #(
        .TABLE_DEPTH(TABLE_DEPTH)
    ) dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_s_axis_tvalid(s_valid),
        .o_s_axis_tready(s_ready),
        .i_s_axis_tdata (s_data),    // character, entry_char, entry_code, zero pad
        .i_s_axis_tuser (s_user),    // cmd
        .o_m_axis_tvalid(m_valid),
        .i_m_axis_tready(m_ready),
        .o_m_axis_tdata (m_data),    // key_code, key_release, zero pad
        .o_m_axis_tuser (m_user),    // status
        .o_m_axis_tlast (m_last)
    );

    t_text_word text_words_q[$];
    t_keystroke keystroke_q[$];

    // encoder state as seen by the testbench
    logic [7:0]        key_table_char[TABLE_DEPTH];
    logic signed [8:0] key_table_code[TABLE_DEPTH];
    int                key_table_count = 0;

    int error_count = 0;
    int cycle_count = 0;
    int words_checked = 0;
    int typed_count = 0;
    int load_count = 0;
    int hit_count = 0;
    int miss_count = 0;
    int full_count = 0;

    int burst_left = 0;
    int gap_left = 0;
    int stall_mode = 0;
    int stall_phase = 0;

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("Some tests failed");
            $finish;
        end
    end

    function automatic bit is_fixed_byte(input logic [7:0] ch);
        return (ch >= CHR_ZERO && ch <= CHR_NINE) || (ch >= CHR_UP_A && ch <= CHR_UP_Z) ||
               (ch >= CHR_LO_A && ch <= CHR_LO_Z) || ch == CHR_SPACE || ch == CHR_TAB ||
               ch == CHR_LF;
    endfunction

    function automatic t_text_word type_word(input logic [7:0] ch);
        t_text_word w;
        w.cmd = CMD_TYPE;
        w.ch = ch;
        w.entry_char = 8'($urandom);
        w.entry_code = 9'($urandom);
        return w;
    endfunction

    function automatic t_text_word load_word(input logic [7:0] ech, input logic signed [8:0] code);
        t_text_word w;
        w.cmd = CMD_LOAD;
        w.ch = 8'($urandom);
        w.entry_char = ech;
        w.entry_code = code;
        return w;
    endfunction

    task automatic queue_word(input t_text_word w);
        text_words_q = {text_words_q, w};
    endtask

    task automatic push_event(input logic [7:0] code, input logic rel, input logic [1:0] st,
                              input logic last);
        t_keystroke k;
        k.code = code;
        k.release_flag = rel;
        k.status = st;
        k.last = last;
        keystroke_q = {keystroke_q, k};
    endtask

    task automatic push_tap(input logic [7:0] code);
        push_event(code, 1'b0, ST_KEY, 1'b0);
        push_event(code, 1'b1, ST_KEY, 1'b1);
    endtask

    task automatic push_shifted(input logic [7:0] code);
        push_event(SHIFT_KEY, 1'b0, ST_KEY, 1'b0);
        push_event(code, 1'b0, ST_KEY, 1'b0);
        push_event(code, 1'b1, ST_KEY, 1'b0);
        push_event(SHIFT_KEY, 1'b1, ST_KEY, 1'b1);
    endtask

    task automatic predict_keystrokes(input t_text_word w);
        int  found;
        int  mag;
        logic [7:0] ch;
        found = -1;
        ch = w.ch;
        if (w.cmd == CMD_LOAD) begin
            load_count++;
            if (key_table_count < TABLE_DEPTH) begin
                key_table_char[key_table_count] = w.entry_char;
                key_table_code[key_table_count] = w.entry_code;
                key_table_count++;
                push_event(8'd0, 1'b0, ST_STORED, 1'b1);
            end else begin
                full_count++;
                push_event(8'd0, 1'b0, ST_FULL, 1'b1);
            end
        end else begin
            typed_count++;
            if (ch >= CHR_ZERO && ch <= CHR_NINE) begin
                push_tap(ch);
            end else if (ch >= CHR_UP_A && ch <= CHR_UP_Z) begin
                push_shifted(ch);
            end else if (ch >= CHR_LO_A && ch <= CHR_LO_Z) begin
                // lowercase ends with a lone shift release
                push_event(ch - CASE_OFFSET, 1'b0, ST_KEY, 1'b0);
                push_event(ch - CASE_OFFSET, 1'b1, ST_KEY, 1'b0);
                push_event(SHIFT_KEY, 1'b1, ST_KEY, 1'b1);
            end else if (ch == CHR_SPACE) begin
                push_tap(CODE_SPACE);
            end else if (ch == CHR_TAB) begin
                push_tap(CODE_TAB);
            end else if (ch == CHR_LF) begin
                push_tap(CODE_ENTER);
            end else begin
                for (int i = 0; i < key_table_count; i++) begin
                    if (found < 0 && key_table_char[i] == ch) found = i;
                end
                if (found < 0) begin
                    miss_count++;
                    push_event(8'd0, 1'b0, ST_MISS, 1'b1);
                end else begin
                    hit_count++;
                    if (key_table_code[found] < 0) begin
                        mag = -int'(key_table_code[found]);
                        if (mag > 255) mag = 255;
                        push_shifted(8'(mag));
                    end else begin
                        push_tap(key_table_code[found][7:0]);
                    end
                end
            end
        end
    endtask

    // sender: bursts of words separated by random gaps
    always @(posedge i_clk) begin
        t_text_word w;
        if (!i_rst_n) begin
            s_valid <= 1'b0;
        end else begin
            if (s_valid && s_ready) begin
                w.cmd = s_user[0];
                w.ch = s_data[7:0];
                w.entry_char = s_data[15:8];
                w.entry_code = s_data[24:16];
                predict_keystrokes(w);
            end
            if (!s_valid || s_ready) begin
                if (gap_left > 0) begin
                    gap_left--;
                    s_valid <= 1'b0;
                end else if (text_words_q.size() > 0) begin
                    w = text_words_q.pop_front();
                    s_data <= {7'd0, w.entry_code, w.entry_char, w.ch};
                    s_user <= w.cmd;
                    s_valid <= 1'b1;
                    if (burst_left > 0) begin
                        burst_left--;
                    end else begin
                        burst_left = $urandom_range(1, 16);
                        gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
                    end
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // receiver: picks a new stall mode whenever its phase counter runs out
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            m_ready <= 1'b0;
        end else begin
            if (stall_phase == 0) begin
                stall_mode = $urandom_range(0, 3);
                stall_phase = $urandom_range(20, 120);
            end else begin
                stall_phase--;
            end
            case (stall_mode)
                0: m_ready <= 1'b1;
                1: m_ready <= ($urandom_range(0, 9) < 6);
                2: m_ready <= (cycle_count % 3 != 0);
                default: m_ready <= ($urandom_range(0, 9) < 2);
            endcase
        end
    end

    always @(posedge i_clk) begin
        t_keystroke want;
        if (i_rst_n && m_valid && m_ready) begin
            if (keystroke_q.size() == 0) begin
                $error("unexpected word: key_code %0d release %0d status %0d last %0d",
                       m_data[7:0], m_data[8], m_user, m_last);
                error_count++;
            end else begin
                want = keystroke_q.pop_front();
                words_checked++;
                if (m_data[7:0] !== want.code) begin
                    $error("key_code: expected %0d, got %0d", want.code, m_data[7:0]);
                    error_count++;
                end
                if (m_data[8] !== want.release_flag) begin
                    $error("key_release: expected %0d, got %0d", want.release_flag, m_data[8]);
                    error_count++;
                end
                if (m_user !== want.status) begin
                    $error("status: expected %0d, got %0d", want.status, m_user);
                    error_count++;
                end
                if (m_last !== want.last) begin
                    $error("last: expected %0d, got %0d", want.last, m_last);
                    error_count++;
                end
            end
        end
    end

    initial begin
        logic [7:0] loaded_chars[$];
        logic [7:0] ech;
        int         r;
        int         pick;

        // directed: miss on empty table, first match wins, code extremes
        queue_word(type_word(8'h21));
        queue_word(load_word(8'h21, 9'sd49));
        queue_word(load_word(8'h21, -9'sd50));
        queue_word(type_word(8'h21));
        queue_word(load_word(8'h23, 9'h100));
        queue_word(type_word(8'h23));
        queue_word(load_word(8'h24, -9'sd255));
        queue_word(type_word(8'h24));
        queue_word(load_word(8'h25, 9'sd255));
        queue_word(type_word(8'h25));
        queue_word(load_word(8'h26, 9'sd0));
        queue_word(type_word(8'h26));
        // entry for a fixed-map byte is stored but ignored
        queue_word(load_word(CHR_LO_A, 9'sd77));
        queue_word(type_word(CHR_LO_A));
        queue_word(type_word(CHR_ZERO));
        queue_word(type_word(CHR_NINE));
        queue_word(type_word(CHR_UP_A));
        queue_word(type_word(CHR_UP_Z));
        queue_word(type_word(CHR_LO_Z));
        queue_word(type_word(CHR_SPACE));
        queue_word(type_word(CHR_TAB));
        queue_word(type_word(CHR_LF));
        queue_word(type_word(8'hFF));
        queue_word(type_word(8'h00));
        loaded_chars = {8'h21, 8'h23, 8'h24, 8'h25, 8'h26};

        // random: loads keep coming past a full table
        for (int n = 0; n < RANDOM_WORDS; n++) begin
            r = $urandom_range(0, 99);
            if (r < 20) begin
                ech = 8'($urandom);
                if ($urandom_range(0, 1) == 1) begin
                    while (is_fixed_byte(ech)) ech = 8'($urandom);
                end
                loaded_chars = {loaded_chars, ech};
                queue_word(load_word(ech, 9'($urandom)));
            end else if (r < 50) begin
                pick = $urandom_range(0, 5);
                case (pick)
                    0: ech = CHR_ZERO + 8'($urandom_range(0, 9));
                    1: ech = CHR_UP_A + 8'($urandom_range(0, 25));
                    2: ech = CHR_LO_A + 8'($urandom_range(0, 25));
                    3: ech = CHR_SPACE;
                    4: ech = CHR_TAB;
                    default: ech = CHR_LF;
                endcase
                queue_word(type_word(ech));
            end else if (r < 80) begin
                ech = loaded_chars[$urandom_range(0, loaded_chars.size() - 1)];
                queue_word(type_word(ech));
            end else begin
                queue_word(type_word(8'($urandom)));
            end
        end

        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        wait (text_words_q.size() == 0 && !s_valid);
        wait (keystroke_q.size() == 0);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (keystroke_q.size() != 0) begin
            $error("%0d expected words never arrived", keystroke_q.size());
            error_count++;
        end
        $display("covered %0d typed bytes and %0d table loads, %0d output words checked",
                 typed_count, load_count, words_checked);
        $display("table lookups: %0d hits, %0d misses; %0d loads refused on a full table",
                 hit_count, miss_count, full_count);
        if (error_count == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule
